>>> src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by the cell, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int DATA_W  = 32;
	localparam int PRIO_W  = 16;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 88;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic signed [PRIO_W-1:0] prio;
		logic signed [DATA_W-1:0] data;
	} spq_cmd_t;

endpackage

`default_nettype wire

>>> src/sorted_priority_queue.sv
// Sorted priority queue: one transaction per cycle while the output is drained, result registered.
// Every push or pop is resolved in the cycle it is accepted by all cells in parallel;
// the result appears on the output the next cycle. s_tready stays high while the
// output register is empty or being drained, so the sustained rate is one per cycle.
// Reset clears the entry count, the output valid and the status; slot contents are left as they are.
// Top level; depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [spq_pkg::IN_TDATA_W-1:0]       s_tdata,  // item_data, item_priority
	input  wire                                  s_tuser,  // kind
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// popped_data, front_data, front_priority, entry_count, status, zero pad
	output logic [spq_pkg::OUT_TDATA_W-1:0]      m_tdata
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                                   in_fire;
	logic                                   is_pop;
	logic                                   full;
	logic                                   empty;
	logic [CNT_W-1:0]                       count_q;
	logic                                   m_tvalid_q;
	logic signed [spq_pkg::DATA_W-1:0]      popped_q;
	spq_pkg::spq_status_t                   status_q;
	spq_pkg::spq_cmd_t                      cmd;
	logic [spq_pkg::COUNT_W-1:0]            count_out;
	logic signed [spq_pkg::DATA_W-1:0]      front_data;
	logic signed [spq_pkg::PRIO_W-1:0]      front_prio;

	logic                                   shift   [CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0]      c_data  [CAPACITY];
	logic signed [spq_pkg::PRIO_W-1:0]      c_prio  [CAPACITY];

	assign s_tready = !m_tvalid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;
	assign is_pop   = (s_tuser == spq_pkg::KIND_POP);
	assign full     = (count_q >= CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	always_comb begin
		cmd.push = in_fire && !is_pop && !full;
		cmd.pop  = in_fire && is_pop && !empty;
		cmd.data = s_tdata[spq_pkg::DATA_W-1:0];
		cmd.prio = s_tdata[spq_pkg::DATA_W +: spq_pkg::PRIO_W];
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic                              lshift;
		logic signed [spq_pkg::DATA_W-1:0] ldata;
		logic signed [spq_pkg::PRIO_W-1:0] lprio;
		logic signed [spq_pkg::DATA_W-1:0] rdata;
		logic signed [spq_pkg::PRIO_W-1:0] rprio;

		if (i == 0) begin : g_first
			assign lshift = 1'b0;
			assign ldata  = c_data[i];
			assign lprio  = c_prio[i];
		end else begin : g_mid
			assign lshift = shift[i-1];
			assign ldata  = c_data[i-1];
			assign lprio  = c_prio[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rdata = c_data[i];
			assign rprio = c_prio[i];
		end else begin : g_next
			assign rdata = c_data[i+1];
			assign rprio = c_prio[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.head       (i == 0),
			.occupied   (IDX < count_q),
			.tail       (IDX == count_q),
			.left_shift (lshift),
			.left_data  (ldata),
			.left_prio  (lprio),
			.right_data (rdata),
			.right_prio (rprio),
			.shift      (shift[i]),
			.data_q     (c_data[i]),
			.prio_q     (c_prio[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			status_q   <= spq_pkg::ST_OK;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (in_fire) begin
				m_tvalid_q <= 1'b1;
				if (is_pop && empty) begin
					status_q <= spq_pkg::ST_EMPTY;
				end else if (!is_pop && full) begin
					status_q <= spq_pkg::ST_FULL;
				end else begin
					status_q <= spq_pkg::ST_OK;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			popped_q <= cmd.pop ? c_data[0] : '0;
		end
	end

	// front and count are read live: they only move on a transaction that also reloads the output
	assign count_out  = spq_pkg::COUNT_W'(count_q);
	assign front_data = (count_q == '0) ? '0 : c_data[0];
	assign front_prio = (count_q == '0) ? '0 : c_prio[0];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, status_q, count_out, front_prio, front_data, popped_q};

endmodule

`default_nettype wire

>>> src/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it against a pushed
// priority and shifts toward either neighbor. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input  wire                                     clk,
	input  spq_pkg::spq_cmd_t                       cmd,
	input  wire                                     head,
	input  wire                                     occupied,
	input  wire                                     tail,
	input  wire                                     left_shift,
	input  wire  logic signed [spq_pkg::DATA_W-1:0] left_data,
	input  wire  logic signed [spq_pkg::PRIO_W-1:0] left_prio,
	input  wire  logic signed [spq_pkg::DATA_W-1:0] right_data,
	input  wire  logic signed [spq_pkg::PRIO_W-1:0] right_prio,
	output logic                                    shift,
	output logic signed [spq_pkg::DATA_W-1:0]       data_q,
	output logic signed [spq_pkg::PRIO_W-1:0]       prio_q
);

	logic moves_back;

	// head keeps its place on equal priority; a later slot with equal priority moves back
	// behind the newcomer
	assign moves_back = head ? (prio_q > cmd.prio) : (prio_q >= cmd.prio);
	assign shift      = occupied && moves_back;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (left_shift) begin
				data_q <= left_data;
				prio_q <= left_prio;
			end else if (shift || tail) begin
				data_q <= cmd.data;
				prio_q <= cmd.prio;
			end
		end else if (cmd.pop) begin
			data_q <= right_data;
			prio_q <= right_prio;
		end
	end

endmodule

`default_nettype wire

>>> src/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module spq_checker #(
	parameter int CAPACITY = 16
) (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 s_tvalid,
	input wire                                 s_tready,
	input wire                                 m_tvalid,
	input wire                                 m_tready,
	input wire [spq_pkg::OUT_TDATA_W-1:0]      m_tdata
);

	logic [spq_pkg::COUNT_W-1:0] count_f;
	logic [spq_pkg::STAT_W-1:0]  status_f;
	logic [spq_pkg::COUNT_W-1:0] cap_f;

	assign count_f  = m_tdata[84:80];
	assign status_f = m_tdata[86:85];
	assign cap_f    = spq_pkg::COUNT_W'(CAPACITY);

	// a pop on an empty queue reports an empty queue and nothing popped
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_f == spq_pkg::ST_EMPTY |-> count_f == '0 && m_tdata[31:0] == '0)
		else $error("empty pop reported with entries or data");

	// a dropped push only happens with the queue at capacity
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_f == spq_pkg::ST_FULL |-> count_f == cap_f)
		else $error("full status with queue below capacity");

	// an empty queue shows a zero front entry
	a_front_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && count_f == '0 |-> m_tdata[79:32] == '0)
		else $error("front entry nonzero on empty queue");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every accepted transaction shows a result on the next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted transaction");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

`default_nettype wire
